>>> hw/rtl/tcse_pkg.sv
// Shared types, state codes and constants for the TCP connection state engine.
// No dependencies.
package tcse_pkg;

	localparam int unsigned ConnSlotsDefault = 8;
	localparam logic [15:0] PortBase = 16'd49152;
	localparam logic [15:0] WindowReset = 16'd8192;

	localparam logic [1:0] CmdSegment = 2'd0;
	localparam logic [1:0] CmdOpen = 2'd1;
	localparam logic [1:0] CmdClose = 2'd2;
	localparam logic [1:0] CmdSend = 2'd3;

	localparam logic [1:0] StatOk = 2'd0;
	localparam logic [1:0] StatIgnored = 2'd1;
	localparam logic [1:0] StatFull = 2'd2;
	localparam logic [1:0] StatBad = 2'd3;

	localparam logic [0:0] CfgIfAddr = 1'd0;
	localparam logic [0:0] CfgWindow = 1'd1;

	localparam logic [5:0] FlFin = 6'h01;
	localparam logic [5:0] FlSyn = 6'h02;
	localparam logic [5:0] FlPsh = 6'h08;
	localparam logic [5:0] FlAck = 6'h10;

	typedef enum logic [3:0] {
		TcpClosed = 4'd0, TcpListen = 4'd1, TcpSynSent = 4'd2, TcpSynRcvd = 4'd3,
		TcpEstab = 4'd4, TcpFinWait1 = 4'd5, TcpFinWait2 = 4'd6, TcpCloseWait = 4'd7,
		TcpClosing = 4'd8, TcpLastAck = 4'd9, TcpTimeWait = 4'd10
	} tcp_state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic latch;      // capture the input item
		logic scan;       // examine one slot
		logic decide;     // work out the action
		logic emit;       // drive one result
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scan_done;
		logic emit_last;
	} dp_stat_t;

endpackage

>>> hw/rtl/tcse_ctrl.sv
// Controller state machine of the TCP connection state engine.
// Depends on tcse_pkg.
module tcse_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output tcse_pkg::dp_cmd_t cmd_o,
	input  tcse_pkg::dp_stat_t stat_i
);

	typedef enum logic [3:0] {
		CtlIdle = 4'b0001, CtlScan = 4'b0010, CtlDecide = 4'b0100, CtlEmit = 4'b1000
	} ctl_state_t;

	ctl_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CtlIdle: if (start) state_d = CtlScan;
			CtlScan: if (stat_i.scan_done) state_d = CtlDecide;
			CtlDecide: state_d = CtlEmit;
			CtlEmit: if (stat_i.emit_last) state_d = CtlIdle;
			default: state_d = CtlIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CtlIdle;
		else state_q <= state_d;
	end

	assign busy = (state_q != CtlIdle);
	assign cmd_o.latch = (state_q == CtlIdle) && start;
	assign cmd_o.scan = (state_q == CtlScan);
	assign cmd_o.decide = (state_q == CtlDecide);
	assign cmd_o.emit = (state_q == CtlEmit);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CtlIdle && start) |=> state_q == CtlScan)
		else $error("accepted item did not start a scan");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CtlDecide |=> state_q == CtlEmit)
		else $error("decision not followed by emission");

endmodule

>>> hw/rtl/tcse_dp.sv
// Datapath of the TCP connection state engine: connection table, scan, actions, results.
// Depends on tcse_pkg.
module tcse_dp #(
	parameter int unsigned CONN_SLOTS = tcse_pkg::ConnSlotsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  tcse_pkg::dp_cmd_t cmd_i,
	output tcse_pkg::dp_stat_t stat_o,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0] cmd,
	input  logic [31:0] peer_ip,
	input  logic [15:0] peer_port,
	input  logic [31:0] local_ip_in,
	input  logic [15:0] local_port_in,
	input  logic [31:0] seg_seq,
	input  logic [31:0] seg_ack,
	input  logic [5:0] seg_flags,
	input  logic [3:0] header_words,
	input  logic [15:0] segment_length,
	input  logic [2:0] handle,
	input  logic [15:0] send_length,
	output logic valid,
	output logic sends_segment,
	output logic [5:0] out_flags,
	output logic [31:0] out_src_ip,
	output logic [31:0] out_dst_ip,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port,
	output logic [31:0] out_seq,
	output logic [31:0] out_ack,
	output logic [15:0] out_payload_len,
	output logic [2:0] out_slot,
	output logic [1:0] status,
	output logic last
);

	localparam int unsigned SW = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
	localparam int unsigned CW = $clog2(CONN_SLOTS + 1);

	// Table
	logic [CONN_SLOTS-1:0] ev_q;
	tcse_pkg::tcp_state_t st_q [CONN_SLOTS];
	logic [31:0] lip_q [CONN_SLOTS];
	logic [15:0] lport_q [CONN_SLOTS];
	logic [31:0] rip_q [CONN_SLOTS];
	logic [15:0] rport_q [CONN_SLOTS];
	logic [31:0] sseq_q [CONN_SLOTS];
	logic [31:0] rack_q [CONN_SLOTS];
	logic [15:0] next_port_q;
	logic [31:0] if_addr_q;
	logic [15:0] window_q;

	// Item
	logic [1:0] cmd_q;
	logic [31:0] pip_q, lipi_q, seq_q, ack_q;
	logic [15:0] pport_q, lporti_q, slen_q, dlen_q;
	logic [5:0] fl_q;
	logic [5:0] hlen_q;
	logic [2:0] hnd_q;
	logic [15:0] port_q;

	// Scan
	logic [CW-1:0] idx_q;
	logic match_f_q, free_f_q;
	logic [SW-1:0] match_q, free_q;

	// Results queue
	logic [1:0] n_q, k_q;
	logic [5:0] rfl_q [3];
	logic [15:0] plen_q;
	logic only_q;
	logic ack_lag_q;
	logic [1:0] stat_q;
	logic [SW-1:0] s_q;
	logic [31:0] seq_cur_q;

	logic [SW-1:0] idx_s;
	assign idx_s = idx_q[SW-1:0];

	logic [SW-1:0] hnd_s;
	assign hnd_s = SW'(hnd_q);

	logic hit;
	assign hit = ev_q[idx_s] && lip_q[idx_s] == lipi_q && lport_q[idx_s] == lporti_q
		&& rip_q[idx_s] == pip_q && rport_q[idx_s] == pport_q;

	assign stat_o.scan_done = (idx_q == CW'(CONN_SLOTS - 1))
		|| (cmd_q == tcse_pkg::CmdClose) || (cmd_q == tcse_pkg::CmdSend)
		|| (cmd_q == tcse_pkg::CmdOpen && !ev_q[idx_s])
		|| (cmd_q == tcse_pkg::CmdSegment && hit);
	assign stat_o.emit_last = (k_q + 2'd1 == n_q) || only_q;

	// Decide combinationally.
	logic d_only;
	logic [1:0] d_stat, d_n;
	logic [SW-1:0] d_s;
	logic [5:0] d_f0, d_f1, d_f2;
	logic [15:0] d_plen;
	logic d_create, d_wst, d_wseq, d_wack, d_cr_open;
	tcse_pkg::tcp_state_t d_st;
	logic [31:0] d_seqv, d_ackv;
	logic [15:0] seg_dlen;
	logic h_ok;
	tcse_pkg::tcp_state_t cs;

	assign seg_dlen = slen_q - {10'd0, hlen_q};

	always_comb begin
		d_only = 1'b1; d_stat = tcse_pkg::StatOk; d_n = 2'd1; d_s = match_q;
		d_f0 = '0; d_f1 = '0; d_f2 = '0; d_plen = '0;
		d_create = 1'b0; d_cr_open = 1'b0; d_wst = 1'b0; d_st = tcse_pkg::TcpClosed;
		d_wseq = 1'b0; d_seqv = '0; d_wack = 1'b0; d_ackv = '0;
		h_ok = (32'(hnd_q) < CONN_SLOTS) && ev_q[hnd_s];
		cs = st_q[match_q];
		case (cmd_q)
			tcse_pkg::CmdSegment: begin
				if (slen_q < 16'd20 || {10'd0, hlen_q} > slen_q) begin
					d_stat = tcse_pkg::StatIgnored; d_s = '0;
				end else if (!match_f_q) begin
					d_s = free_q;
					if (!fl_q[1]) begin d_stat = tcse_pkg::StatIgnored; d_s = '0; end
					else if (!free_f_q) begin d_stat = tcse_pkg::StatFull; d_s = '0; end
					else begin
						d_create = 1'b1; d_wst = 1'b1; d_st = tcse_pkg::TcpSynRcvd;
						d_wack = 1'b1; d_ackv = seq_q + 32'd1; d_wseq = 1'b1;
						d_only = 1'b0; d_f0 = tcse_pkg::FlSyn | tcse_pkg::FlAck;
					end
				end else begin
					d_seqv = sseq_q[match_q]; d_ackv = rack_q[match_q];
					case (cs)
						tcse_pkg::TcpSynSent:
							if (fl_q[1] && fl_q[4]) begin
								d_wack = 1'b1; d_ackv = seq_q + 32'd1;
								d_wseq = 1'b1; d_seqv = ack_q;
								d_wst = 1'b1; d_st = tcse_pkg::TcpEstab;
								d_only = 1'b0; d_f0 = tcse_pkg::FlAck;
							end
						tcse_pkg::TcpSynRcvd:
							if (fl_q[4]) begin
								d_wseq = 1'b1; d_seqv = ack_q;
								d_wst = 1'b1; d_st = tcse_pkg::TcpEstab;
							end
						tcse_pkg::TcpEstab: begin
							if (seg_dlen != 16'd0) begin
								d_wack = 1'b1; d_ackv = seq_q + {16'd0, seg_dlen};
								d_only = 1'b0; d_f0 = tcse_pkg::FlAck;
							end
							if (fl_q[0]) begin
								d_wack = 1'b1; d_ackv = d_ackv + 32'd1;
								d_wst = 1'b1; d_st = tcse_pkg::TcpLastAck;
								if (d_only) begin
									d_f0 = tcse_pkg::FlAck; d_f1 = tcse_pkg::FlFin | tcse_pkg::FlAck;
									d_n = 2'd2;
								end else begin
									d_f1 = tcse_pkg::FlAck; d_f2 = tcse_pkg::FlFin | tcse_pkg::FlAck;
									d_n = 2'd3;
								end
								d_only = 1'b0;
							end
						end
						tcse_pkg::TcpFinWait1: begin
							if (fl_q[4]) begin d_wst = 1'b1; d_st = tcse_pkg::TcpFinWait2; end
							if (fl_q[0]) begin
								d_wack = 1'b1; d_ackv = d_ackv + 32'd1;
								d_wst = 1'b1;
								d_st = fl_q[4] ? tcse_pkg::TcpTimeWait : tcse_pkg::TcpClosing;
								d_only = 1'b0; d_f0 = tcse_pkg::FlAck;
							end
						end
						tcse_pkg::TcpFinWait2:
							if (fl_q[0]) begin
								d_wack = 1'b1; d_ackv = d_ackv + 32'd1;
								d_wst = 1'b1; d_st = tcse_pkg::TcpTimeWait;
								d_only = 1'b0; d_f0 = tcse_pkg::FlAck;
							end
						tcse_pkg::TcpClosing:
							if (fl_q[4]) begin d_wst = 1'b1; d_st = tcse_pkg::TcpTimeWait; end
						tcse_pkg::TcpLastAck:
							if (fl_q[4]) begin d_wst = 1'b1; d_st = tcse_pkg::TcpClosed; end
						default: ;
					endcase
				end
			end
			tcse_pkg::CmdOpen: begin
				d_s = free_q;
				if (!free_f_q) begin d_stat = tcse_pkg::StatFull; d_s = '0; end
				else begin
					d_create = 1'b1; d_cr_open = 1'b1; d_wst = 1'b1; d_st = tcse_pkg::TcpSynSent;
					d_wseq = 1'b1; d_wack = 1'b1;
					d_only = 1'b0; d_f0 = tcse_pkg::FlSyn;
				end
			end
			tcse_pkg::CmdClose: begin
				d_s = hnd_s;
				if (!h_ok) d_stat = tcse_pkg::StatBad;
				else begin
					case (st_q[hnd_s])
						tcse_pkg::TcpSynSent: begin d_wst = 1'b1; d_st = tcse_pkg::TcpClosed; end
						tcse_pkg::TcpSynRcvd, tcse_pkg::TcpEstab: begin
							d_wst = 1'b1; d_st = tcse_pkg::TcpFinWait1;
							d_only = 1'b0; d_f0 = tcse_pkg::FlFin;
						end
						tcse_pkg::TcpCloseWait: begin
							d_wst = 1'b1; d_st = tcse_pkg::TcpLastAck;
							d_only = 1'b0; d_f0 = tcse_pkg::FlFin;
						end
						default: d_stat = tcse_pkg::StatBad;
					endcase
				end
			end
			default: begin
				d_s = hnd_s;
				if (!h_ok) d_stat = tcse_pkg::StatBad;
				else if (dlen_q == 16'd0) d_stat = tcse_pkg::StatIgnored;
				else if (st_q[hnd_s] != tcse_pkg::TcpEstab) d_stat = tcse_pkg::StatBad;
				else begin
					d_only = 1'b0; d_f0 = tcse_pkg::FlPsh | tcse_pkg::FlAck; d_plen = dlen_q;
				end
			end
		endcase
	end

	logic [31:0] seq_inc;
	logic [5:0] cur_fl;
	assign cur_fl = rfl_q[k_q];
	assign seq_inc = seq_cur_q + {16'd0, plen_q} + {31'd0, (cur_fl[0] | cur_fl[1])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= '0;
			for (int i = 0; i < CONN_SLOTS; i++) st_q[i] <= tcse_pkg::TcpClosed;
			next_port_q <= tcse_pkg::PortBase;
			if_addr_q <= '0;
			window_q <= tcse_pkg::WindowReset;
			valid <= 1'b0;
			idx_q <= '0; k_q <= '0; n_q <= '0; only_q <= 1'b0;
			match_f_q <= 1'b0; free_f_q <= 1'b0;
		end else begin
			valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					tcse_pkg::CfgIfAddr: if_addr_q <= cfg_data;
					default: window_q <= cfg_data[15:0];
				endcase
			end
			if (cmd_i.latch) begin
				idx_q <= '0; match_f_q <= 1'b0; free_f_q <= 1'b0;
				if (cmd == tcse_pkg::CmdOpen)
					next_port_q <= (next_port_q == 16'hFFFF) ? tcse_pkg::PortBase
						: next_port_q + 16'd1;
			end
			if (cmd_i.scan) begin
				if (cmd_q == tcse_pkg::CmdSegment && hit) match_f_q <= 1'b1;
				if (!ev_q[idx_s] && !free_f_q) free_f_q <= 1'b1;
				if (idx_q != CW'(CONN_SLOTS - 1)) idx_q <= idx_q + CW'(1);
			end
			if (cmd_i.decide) begin
				only_q <= d_only; stat_q <= d_stat; n_q <= d_n; k_q <= '0;
				s_q <= d_s; plen_q <= d_plen;
				if (d_create) ev_q[d_s] <= 1'b1;
				if (d_wst) begin
					st_q[d_s] <= d_st;
					if (d_st == tcse_pkg::TcpClosed) ev_q[d_s] <= 1'b0;
				end
			end
			if (cmd_i.emit) begin
				valid <= 1'b1;
				k_q <= k_q + 2'd1;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd_i.latch) begin
			cmd_q <= cmd; pip_q <= peer_ip; pport_q <= peer_port;
			lipi_q <= local_ip_in; lporti_q <= local_port_in;
			seq_q <= seg_seq; ack_q <= seg_ack; fl_q <= seg_flags;
			hlen_q <= {header_words, 2'b00}; slen_q <= segment_length;
			hnd_q <= handle; dlen_q <= send_length; port_q <= next_port_q;
		end
		if (cmd_i.scan) begin
			if (cmd_q == tcse_pkg::CmdSegment && hit && !match_f_q) match_q <= idx_s;
			if (!ev_q[idx_s] && !free_f_q) free_q <= idx_s;
		end
		if (cmd_i.decide) begin
			rfl_q[0] <= d_f0; rfl_q[1] <= d_f1; rfl_q[2] <= d_f2;
			// With data and a FIN together, the first acknowledgement precedes the FIN.
			ack_lag_q <= (d_n == 2'd3);
			if (d_create) begin
				lip_q[d_s] <= d_cr_open ? if_addr_q : lipi_q;
				lport_q[d_s] <= d_cr_open ? port_q : lporti_q;
				rip_q[d_s] <= pip_q; rport_q[d_s] <= pport_q;
			end
			if (d_wseq) sseq_q[d_s] <= d_create ? 32'd0 : d_seqv;
			if (d_wack) rack_q[d_s] <= d_cr_open ? 32'd0 : d_ackv;
			seq_cur_q <= d_create ? 32'd0 : (d_wseq ? d_seqv : sseq_q[d_s]);
		end
		if (cmd_i.emit) begin
			sends_segment <= !only_q;
			out_flags <= only_q ? 6'd0 : cur_fl;
			out_src_ip <= only_q ? 32'd0 : lip_q[s_q];
			out_dst_ip <= only_q ? 32'd0 : rip_q[s_q];
			out_src_port <= only_q ? 16'd0 : lport_q[s_q];
			out_dst_port <= only_q ? 16'd0 : rport_q[s_q];
			out_seq <= only_q ? 32'd0 : seq_cur_q;
			out_ack <= only_q ? 32'd0
				: rack_q[s_q] - {31'd0, (ack_lag_q && k_q == 2'd0)};
			out_payload_len <= only_q ? 16'd0 : plen_q;
			out_slot <= 3'(s_q);
			status <= only_q ? stat_q : tcse_pkg::StatOk;
			last <= stat_o.emit_last;
			if (!only_q) begin
				seq_cur_q <= seq_inc;
				sseq_q[s_q] <= seq_inc;
			end
		end
	end

	a_n: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.emit && !only_q |-> n_q != 2'd0 && k_q < n_q)
		else $error("emission beyond result count");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !cmd_i.emit)
		else $error("emission continued after last result");
	a_win: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(window_q))
		else $error("window changed without a write");

endmodule

>>> hw/rtl/tcp_connection_state_engine.sv
// Top level of the TCP connection state engine.
// Depends on tcse_pkg, tcse_ctrl and tcse_dp.
//
// An item is accepted only while busy is low, and busy stays high until its last result has
// been shown. The slot scan examines, for a received segment, up to CONN_SLOTS slots,
// stopping at the first match; for an open, slots up to the first free one; for a close or a
// send, one slot. An item yields one to three results. The slot scan reads one entry a cycle.
// Results are strobed by valid for one cycle each and cannot be held off.
// The table is empty after reset and needs no clearing pass.
module tcp_connection_state_engine #(
	parameter int unsigned CONN_SLOTS = tcse_pkg::ConnSlotsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0] cmd,
	input  logic [31:0] peer_ip,
	input  logic [15:0] peer_port,
	input  logic [31:0] local_ip_in,
	input  logic [15:0] local_port_in,
	input  logic [31:0] seg_seq,
	input  logic [31:0] seg_ack,
	input  logic [5:0] seg_flags,
	input  logic [3:0] header_words,
	input  logic [15:0] segment_length,
	input  logic [2:0] handle,
	input  logic [15:0] send_length,
	output logic valid,
	output logic sends_segment,
	output logic [5:0] out_flags,
	output logic [31:0] out_src_ip,
	output logic [31:0] out_dst_ip,
	output logic [15:0] out_src_port,
	output logic [15:0] out_dst_port,
	output logic [31:0] out_seq,
	output logic [31:0] out_ack,
	output logic [15:0] out_payload_len,
	output logic [2:0] out_slot,
	output logic [1:0] status,
	output logic last
);

	tcse_pkg::dp_cmd_t dcmd;
	tcse_pkg::dp_stat_t dstat;
	logic ctl_busy;

	// Busy covers the cycle in which the last result is shown.
	assign busy = ctl_busy || valid;

	tcse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start && !valid), .busy(ctl_busy),
		.cmd_o(dcmd), .stat_i(dstat)
	);

	tcse_dp #(.CONN_SLOTS(CONN_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_i(dcmd), .stat_o(dstat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .peer_ip(peer_ip), .peer_port(peer_port),
		.local_ip_in(local_ip_in), .local_port_in(local_port_in),
		.seg_seq(seg_seq), .seg_ack(seg_ack), .seg_flags(seg_flags),
		.header_words(header_words), .segment_length(segment_length),
		.handle(handle), .send_length(send_length),
		.valid(valid), .sends_segment(sends_segment), .out_flags(out_flags),
		.out_src_ip(out_src_ip), .out_dst_ip(out_dst_ip),
		.out_src_port(out_src_port), .out_dst_port(out_dst_port),
		.out_seq(out_seq), .out_ack(out_ack), .out_payload_len(out_payload_len),
		.out_slot(out_slot), .status(status), .last(last)
	);

endmodule
